// File: rtl/core/escrc_pkg.sv
// ----------------------------------------------------------------------------
// escrc_pkg : shared types and constants for the escape stuffing codec
// Register indexes, reset values, the CRC-8 step function and the structs
// that pass between the codec modules.
// ----------------------------------------------------------------------------
package escrc_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 8;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] REG_DECODE_MODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SYNC_SYMBOL   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ESCAPE_SYMBOL = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SYNC_CODE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ESCAPE_CODE   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CRC_START     = 3'd5;

   // reset values
   localparam logic       RST_DECODE_MODE   = 1'b0;
   localparam logic [7:0] RST_SYNC_SYMBOL   = 8'hAA;
   localparam logic [7:0] RST_ESCAPE_SYMBOL = 8'hA9;
   localparam logic [7:0] RST_SYNC_CODE     = 8'h01;
   localparam logic [7:0] RST_ESCAPE_CODE   = 8'h00;
   localparam logic [7:0] RST_CRC_START     = 8'h00;

   localparam logic [7:0] CRC_POLY = 8'h9B;

   typedef struct packed {
      logic       decode_mode;
      logic [7:0] sync_symbol;
      logic [7:0] escape_symbol;
      logic [7:0] sync_code;
      logic [7:0] escape_code;
      logic [7:0] crc_start;
   } cfg_type;

   // one result as worked out from the held item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [7:0] crc_next;
      logic       run_last;
      logic       pending_next;
   } step_type;

   // crc * x^8 mod 0x19B, then xor the new byte
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] v;
      v = crc;
      for (int i = 0; i < 8; i++) begin
         v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
      end
      return v ^ data;
   endfunction

endpackage

// File: rtl/core/escrc_req_if.sv
// ----------------------------------------------------------------------------
// escrc_req_if : input channel of the codec
// Valid/ready channel carrying one frame byte and its end-of-frame mark.
// ----------------------------------------------------------------------------
interface escrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       frame_last;

   modport source (output valid, output data_byte, output frame_last, input ready);
   modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

// File: rtl/core/escrc_rsp_if.sv
// ----------------------------------------------------------------------------
// escrc_rsp_if : result channel of the codec
// Valid/ready channel carrying one produced byte with its CRC and markers.
// ----------------------------------------------------------------------------
interface escrc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic [7:0] running_crc;
   logic       run_last;
   logic       frame_end;

   modport source (output valid, output out_byte, output byte_valid, output running_crc,
                   output run_last, output frame_end, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input running_crc,
                   input run_last, input frame_end, output ready);
endinterface

// File: rtl/core/escrc_csr.sv
// ----------------------------------------------------------------------------
// escrc_csr : configuration registers
// Write-only register file; out-of-range indexes are ignored.
// ----------------------------------------------------------------------------
module escrc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 wr_en,
   input  logic [escrc_pkg::CSR_INDEX_W-1:0]    index,
   input  logic [escrc_pkg::CSR_DATA_W-1:0]     wdata,
   output escrc_pkg::cfg_type                   cfg
);

   escrc_pkg::cfg_type cfg_ff;
   escrc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            escrc_pkg::REG_DECODE_MODE:   cfg_in.decode_mode   = wdata[0];
            escrc_pkg::REG_SYNC_SYMBOL:   cfg_in.sync_symbol   = wdata;
            escrc_pkg::REG_ESCAPE_SYMBOL: cfg_in.escape_symbol = wdata;
            escrc_pkg::REG_SYNC_CODE:     cfg_in.sync_code     = wdata;
            escrc_pkg::REG_ESCAPE_CODE:   cfg_in.escape_code   = wdata;
            escrc_pkg::REG_CRC_START:     cfg_in.crc_start     = wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decode_mode   <= escrc_pkg::RST_DECODE_MODE;
         cfg_ff.sync_symbol   <= escrc_pkg::RST_SYNC_SYMBOL;
         cfg_ff.escape_symbol <= escrc_pkg::RST_ESCAPE_SYMBOL;
         cfg_ff.sync_code     <= escrc_pkg::RST_SYNC_CODE;
         cfg_ff.escape_code   <= escrc_pkg::RST_ESCAPE_CODE;
         cfg_ff.crc_start     <= escrc_pkg::RST_CRC_START;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/escrc_step.sv
// ----------------------------------------------------------------------------
// escrc_step : per-result codec logic
// Works out one result from the held byte, the phase and the frame state.
// ----------------------------------------------------------------------------
module escrc_step (
   input  escrc_pkg::cfg_type  cfg,
   input  logic [7:0]          data_byte,
   input  logic                phase,      // 1: second result of an expanded byte
   input  logic [7:0]          crc,
   input  logic                pending,
   output escrc_pkg::step_type res
);

   logic       is_sync;
   logic       is_special;
   logic [7:0] code;

   assign is_sync    = (data_byte == cfg.sync_symbol);
   assign is_special = is_sync || (data_byte == cfg.escape_symbol);
   assign code       = is_sync ? cfg.sync_code : cfg.escape_code;

   always_comb begin
      res.pending_next = pending;
      res.run_last     = 1'b1;
      res.byte_valid   = 1'b1;
      if (!cfg.decode_mode) begin
         if (is_special && !phase) begin
            res.out_byte = cfg.escape_symbol;
            res.run_last = 1'b0;
         end else if (is_special) begin
            res.out_byte = code;
         end else begin
            res.out_byte = data_byte;
         end
         res.crc_next = escrc_pkg::crc8_step(crc, res.out_byte);
      end else begin
         res.crc_next = escrc_pkg::crc8_step(crc, data_byte);
         if (is_special) begin
            res.pending_next = 1'b1;
            res.byte_valid   = 1'b0;
            res.out_byte     = 8'h00;
         end else if (pending) begin
            res.pending_next = 1'b0;
            res.out_byte     = (data_byte == cfg.sync_code) ? cfg.sync_symbol
                                                            : cfg.escape_symbol;
         end else begin
            res.out_byte = data_byte;
         end
      end
   end

endmodule

// File: rtl/core/escape_stuffing_codec_with_crc8_top.sv
// ----------------------------------------------------------------------------
// escape_stuffing_codec_with_crc8_top : byte stuffing codec with CRC-8
// Path: input register, then result register, then offered on rsp.
// Throughput: one input per cycle while rsp takes the results; an encoded sync or
//   escape byte holds the input register until both its wire bytes are loaded.
// Reset: synchronous, active high; empties both registers, loads the
//   configuration defaults, CRC to 0x00 and clears the escape flag.
// ----------------------------------------------------------------------------
module escape_stuffing_codec_with_crc8_top (
   input  logic                              clock,
   input  logic                              reset,
   escrc_req_if.sink                         req_chan,
   escrc_rsp_if.source                       rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [escrc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [escrc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   escrc_pkg::cfg_type  cfg;
   escrc_pkg::step_type res;

   // input register: one held item
   logic       hold_valid_ff, hold_valid_in;
   logic [7:0] hold_byte_ff;
   logic       hold_last_ff;
   logic       phase_ff, phase_in;

   // frame state
   logic [7:0] crc_ff, crc_in;
   logic       pending_ff, pending_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] out_byte_ff;
   logic       byte_valid_ff;
   logic [7:0] running_crc_ff;
   logic       run_last_ff;
   logic       frame_end_ff;

   logic req_xfer;
   logic load;        // a result moves into the result register
   logic item_done;   // ...and it is the last one of the held item

   escrc_csr u_csr (
      .clock (clock),
      .reset (reset),
      .wr_en (csr_wr_en),
      .index (csr_index),
      .wdata (csr_wdata),
      .cfg   (cfg)
   );

   escrc_step u_step (
      .cfg       (cfg),
      .data_byte (hold_byte_ff),
      .phase     (phase_ff),
      .crc       (crc_ff),
      .pending   (pending_ff),
      .res       (res)
   );

   // result register frees when empty or when its transfer happens now
   assign load      = hold_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign item_done = load && res.run_last;

   // input register takes a new item when empty or as the current one finishes
   assign req_chan.ready = !hold_valid_ff || item_done;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (req_xfer) begin
         hold_valid_in = 1'b1;
      end else if (item_done) begin
         hold_valid_in = 1'b0;
      end
      phase_in = load ? !res.run_last : phase_ff;

      crc_in     = crc_ff;
      pending_in = pending_ff;
      if (load) begin
         if (item_done && hold_last_ff) begin
            // frame closes: restart CRC, drop any dangling escape
            crc_in     = cfg.crc_start;
            pending_in = 1'b0;
         end else begin
            crc_in     = res.crc_next;
            pending_in = res.pending_next;
         end
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         phase_ff      <= 1'b0;
         crc_ff        <= escrc_pkg::RST_CRC_START;
         pending_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         phase_ff      <= phase_in;
         crc_ff        <= crc_in;
         pending_ff    <= pending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         hold_byte_ff <= req_chan.data_byte;
         hold_last_ff <= req_chan.frame_last;
      end
      if (load) begin
         out_byte_ff    <= res.out_byte;
         byte_valid_ff  <= res.byte_valid;
         running_crc_ff <= res.crc_next;
         run_last_ff    <= res.run_last;
         frame_end_ff   <= res.run_last && hold_last_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_byte    = out_byte_ff;
   assign rsp_chan.byte_valid  = byte_valid_ff;
   assign rsp_chan.running_crc = running_crc_ff;
   assign rsp_chan.run_last    = run_last_ff;
   assign rsp_chan.frame_end   = frame_end_ff;

   // second wire byte only ever pending on a held item
   a_phase_needs_item: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> hold_valid_ff)
      else $error("phase set with empty input register");

   // frame close restarts the CRC and clears the escape flag
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (item_done && hold_last_ff) |=> (crc_ff == $past(cfg.crc_start)) && !pending_ff)
      else $error("frame state not restarted at frame end");

   // frame end only on the closing result of an item
   a_frame_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && frame_end_ff) |-> run_last_ff)
      else $error("frame_end without run_last");

endmodule

// File: test/tb_escape_stuffing_codec_with_crc8_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_escape_stuffing_codec_with_crc8_top : self-checking bench for the codec
// Drives frame bytes over the req channel and checks every rsp transfer
// against a behavioural copy of the codec: escape stuffing or unstuffing
// plus the CRC-8 (poly 0x9B) over the wire form. Directed frames cover the
// corner cases, then random phases vary the register settings from phase to phase.
// ----------------------------------------------------------------------------
module tb_escape_stuffing_codec_with_crc8_top;

   localparam int RANDOM_ITEMS = 400;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   // the csr decoder has room for two more indexes; writes there must be ignored
   localparam logic [escrc_pkg::CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [escrc_pkg::CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic [7:0] running_crc;
      logic       run_last;
      logic       frame_end;
   } codec_result_type;

   logic                              clock;
   logic                              reset;
   logic                              csr_wr_en;
   logic [escrc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [escrc_pkg::CSR_DATA_W-1:0]  csr_wdata;
   logic                              sink_ready = 1'b0;

   escrc_req_if req_if ();
   escrc_rsp_if rsp_if ();

   assign rsp_if.ready = sink_ready;

   escape_stuffing_codec_with_crc8_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the codec: its registers, running CRC and escape flag
   escrc_pkg::cfg_type codec_cfg;
   logic [7:0]         crc_acc;
   logic               escape_seen;
   codec_result_type   due_results[$];

   int  fail_count   = 0;
   int  cycle_count  = 0;
   bit  gaps_enabled = 1'b1;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog: a stuck handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_escape_stuffing_codec_with_crc8_top NOT OK");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // behavioural codec
   // ------------------------------------------------------------------------

   // crc * x^8 mod 0x19B, then xor in the new wire byte
   function automatic logic [7:0] crc8_shift_in(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] v;
      v = crc;
      for (int i = 0; i < 8; i++) begin
         v = {v[6:0], 1'b0} ^ (v[7] ? 8'h9B : 8'h00);
      end
      return v ^ b;
   endfunction

   // works out the one or two results of an accepted byte and queues them
   function automatic void encode_or_decode_byte(input logic [7:0] b, input logic last);
      codec_result_type outs [2];
      int               n;
      logic [7:0]       code;
      n = 0;
      if (!codec_cfg.decode_mode) begin
         if (b == codec_cfg.sync_symbol || b == codec_cfg.escape_symbol) begin
            // sync test wins when both symbols are equal
            code    = (b == codec_cfg.sync_symbol) ? codec_cfg.sync_code : codec_cfg.escape_code;
            crc_acc = crc8_shift_in(crc_acc, codec_cfg.escape_symbol);
            outs[0] = '{codec_cfg.escape_symbol, 1'b1, crc_acc, 1'b0, 1'b0};
            crc_acc = crc8_shift_in(crc_acc, code);
            outs[1] = '{code, 1'b1, crc_acc, 1'b0, 1'b0};
            n = 2;
         end else begin
            crc_acc = crc8_shift_in(crc_acc, b);
            outs[0] = '{b, 1'b1, crc_acc, 1'b0, 1'b0};
            n = 1;
         end
      end else begin
         // CRC always covers the wire byte as received
         crc_acc = crc8_shift_in(crc_acc, b);
         if (b == codec_cfg.sync_symbol || b == codec_cfg.escape_symbol) begin
            escape_seen = 1'b1;
            outs[0] = '{8'h00, 1'b0, crc_acc, 1'b0, 1'b0};
         end else if (escape_seen) begin
            escape_seen = 1'b0;
            outs[0] = '{(b == codec_cfg.sync_code) ? codec_cfg.sync_symbol
                                                   : codec_cfg.escape_symbol,
                        1'b1, crc_acc, 1'b0, 1'b0};
         end else begin
            outs[0] = '{b, 1'b1, crc_acc, 1'b0, 1'b0};
         end
         n = 1;
      end
      outs[n-1].run_last  = 1'b1;
      outs[n-1].frame_end = last;
      if (last) begin
         // new frame: CRC from crc_start, a dangling escape is dropped
         crc_acc     = codec_cfg.crc_start;
         escape_seen = 1'b0;
      end
      for (int k = 0; k < n; k++) due_results.insert(due_results.size(), outs[k]);
   endfunction

   // ------------------------------------------------------------------------
   // result side: random back-pressure and field-by-field compare
   // ------------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %02h, got %02h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      codec_result_type want;
      if (reset) begin
         sink_ready <= 1'b0;
      end else begin
         sink_ready <= gaps_enabled ? ($urandom_range(0, 99) >= 20) : 1'b1;
         if (rsp_if.valid && rsp_if.ready) begin
            if (due_results.size() == 0) begin
               $error("unexpected result transfer: out_byte %02h", rsp_if.out_byte);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               check_field("out_byte", want.out_byte, rsp_if.out_byte);
               check_field("byte_valid", 8'(want.byte_valid), 8'(rsp_if.byte_valid));
               check_field("running_crc", want.running_crc, rsp_if.running_crc);
               check_field("run_last", 8'(want.run_last), 8'(rsp_if.run_last));
               check_field("frame_end", 8'(want.frame_end), 8'(rsp_if.frame_end));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   // one byte transfer; valid stays high afterwards unless a gap is drawn
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (gaps_enabled && $urandom_range(0, 99) < 20) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.data_byte  <= b;
      req_if.frame_last <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      encode_or_decode_byte(b, last);
   endtask

   // quiesce before a register write: no request, all results back, pipe empty
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write_en stays high across back-to-back writes and drops once at the end
   task automatic write_reg(input logic [escrc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [7:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_config(input escrc_pkg::cfg_type cfg, input bit poke_spare);
      write_reg(escrc_pkg::REG_DECODE_MODE, {7'd0, cfg.decode_mode});
      write_reg(escrc_pkg::REG_SYNC_SYMBOL, cfg.sync_symbol);
      write_reg(escrc_pkg::REG_ESCAPE_SYMBOL, cfg.escape_symbol);
      write_reg(escrc_pkg::REG_SYNC_CODE, cfg.sync_code);
      write_reg(escrc_pkg::REG_ESCAPE_CODE, cfg.escape_code);
      write_reg(escrc_pkg::REG_CRC_START, cfg.crc_start);
      if (poke_spare) begin
         write_reg(REG_SPARE_LO, 8'hFF);
         write_reg(REG_SPARE_HI, 8'($urandom));
      end
      csr_wr_en <= 1'b0;
      // crc_start only lands at the next frame start, so crc_acc is left alone
      codec_cfg = cfg;
   endtask

   // bytes biased towards the symbols and codes of the current setting
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0, 1: return codec_cfg.sync_symbol;
         2, 3: return codec_cfg.escape_symbol;
         4: return codec_cfg.sync_code;
         5: return codec_cfg.escape_code;
         default: return 8'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // reset settings: plain bytes at both extremes, sync and escape expansion
   task automatic test_encode_defaults();
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(escrc_pkg::RST_SYNC_SYMBOL, 1'b0);
      send_byte(escrc_pkg::RST_ESCAPE_SYMBOL, 1'b0);
      send_byte(8'h55, 1'b1);
   endtask

   // escape then sync code, escape then other, sync as prefix, double escape,
   // dangling escape at frame end, then a code byte in a fresh frame
   task automatic test_decode_defaults();
      escrc_pkg::cfg_type cfg;
      cfg = '{1'b1, escrc_pkg::RST_SYNC_SYMBOL, escrc_pkg::RST_ESCAPE_SYMBOL,
              escrc_pkg::RST_SYNC_CODE, escrc_pkg::RST_ESCAPE_CODE,
              escrc_pkg::RST_CRC_START};
      wait_idle();
      load_config(cfg, 1'b0);
      send_byte(escrc_pkg::RST_ESCAPE_SYMBOL, 1'b0);
      send_byte(escrc_pkg::RST_SYNC_CODE, 1'b0);
      send_byte(escrc_pkg::RST_ESCAPE_SYMBOL, 1'b0);
      send_byte(escrc_pkg::RST_ESCAPE_CODE, 1'b0);
      send_byte(escrc_pkg::RST_SYNC_SYMBOL, 1'b0);
      send_byte(8'h37, 1'b0);
      send_byte(escrc_pkg::RST_ESCAPE_SYMBOL, 1'b0);
      send_byte(escrc_pkg::RST_ESCAPE_SYMBOL, 1'b0);
      send_byte(escrc_pkg::RST_SYNC_CODE, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(escrc_pkg::RST_ESCAPE_SYMBOL, 1'b1);
      send_byte(escrc_pkg::RST_SYNC_CODE, 1'b1);
   endtask

   // sync and escape share one value; spare indexes written and ignored;
   // mode flipped inside an open frame keeps CRC and escape flag
   task automatic test_equal_symbols();
      escrc_pkg::cfg_type cfg;
      cfg = '{1'b0, 8'h00, 8'h00, 8'hFF, 8'h7F, 8'hFF};
      wait_idle();
      load_config(cfg, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b1);
      send_byte(8'h00, 1'b0);
      wait_idle();
      cfg.decode_mode = 1'b1;
      load_config(cfg, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b1);
   endtask

   // register setting per phase: all-zero, all-ones and one mixed setting first, then random
   function automatic escrc_pkg::cfg_type draw_config(input int phase);
      escrc_pkg::cfg_type cfg;
      case (phase)
         0: cfg = '{1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
         1: cfg = '{1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
         2: cfg = '{1'b0, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF};
         default: begin
            cfg = '{1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom)};
            if ($urandom_range(0, 3) == 0) cfg.escape_symbol = cfg.sync_symbol;
            if ($urandom_range(0, 5) == 0) cfg.escape_code = cfg.sync_code;
         end
      endcase
      return cfg;
   endfunction

   // random phases; frames may stay open across a register change.
   // In decode mode most traffic is well-formed wire form of a raw byte.
   task automatic test_random();
      int         sent;
      int         phase;
      int         span;
      logic [7:0] raw;
      logic       last;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         gaps_enabled = !(phase == 4 || phase == 5);   // long gap-free stretch
         load_config(draw_config(phase), phase == 3);
         span = $urandom_range(20, 50);
         for (int k = 0; k < span && sent < RANDOM_ITEMS; k++) begin
            last = ($urandom_range(0, 7) == 0);
            raw  = pick_byte();
            if (codec_cfg.decode_mode && $urandom_range(0, 9) != 0 &&
                (raw == codec_cfg.sync_symbol || raw == codec_cfg.escape_symbol)) begin
               send_byte(codec_cfg.escape_symbol, 1'b0);
               send_byte((raw == codec_cfg.sync_symbol) ? codec_cfg.sync_code
                                                        : codec_cfg.escape_code, last);
               sent += 2;
            end else begin
               send_byte(raw, last);
               sent++;
            end
         end
         phase++;
      end
      gaps_enabled = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_index         <= escrc_pkg::REG_DECODE_MODE;
      csr_wdata         <= 8'h00;
      req_if.valid      <= 1'b0;
      req_if.data_byte  <= 8'h00;
      req_if.frame_last <= 1'b0;
      codec_cfg   = '{escrc_pkg::RST_DECODE_MODE, escrc_pkg::RST_SYNC_SYMBOL,
                      escrc_pkg::RST_ESCAPE_SYMBOL, escrc_pkg::RST_SYNC_CODE,
                      escrc_pkg::RST_ESCAPE_CODE, escrc_pkg::RST_CRC_START};
      crc_acc     = escrc_pkg::RST_CRC_START;
      escape_seen = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_encode_defaults();
      test_decode_defaults();
      test_equal_symbols();
      test_random();

      // every expectation must be met before the verdict
      wait_idle();
      if (fail_count == 0) begin
         $display("tb_escape_stuffing_codec_with_crc8_top OK");
      end else begin
         $display("tb_escape_stuffing_codec_with_crc8_top NOT OK");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/escrc_pkg.sv
rtl/core/escrc_req_if.sv
rtl/core/escrc_rsp_if.sv
rtl/core/escrc_csr.sv
rtl/core/escrc_step.sv
rtl/core/escape_stuffing_codec_with_crc8_top.sv
test/tb_escape_stuffing_codec_with_crc8_top.sv
